// ===== sv/capture_period_moving_average_macros.svh =====
// Assertion macros for the capture period moving average block.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef CAPTURE_PERIOD_MOVING_AVERAGE_MACROS_SVH
`define CAPTURE_PERIOD_MOVING_AVERAGE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPMA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cpma invariant violated");
`define CPMA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpma implication violated");
`else
`define CPMA_ASSERT_ALWAYS(lbl, cond)
`define CPMA_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== sv/cpma_pkg.sv =====
// Shared constants and types for the capture period moving average block.
// No dependencies; used by the divider and the top level.
package cpma_pkg;

    localparam int DATA_W               = 32;
    localparam int WINDOW_DEPTH_DEFAULT = 512;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== sv/cpma_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cpma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cpma_div.sv =====
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on cpma_pkg for the status struct.
module cpma_div
    import cpma_pkg::*;
#(
    parameter int DIVIDEND_W = 41,
    parameter int DIVISOR_W  = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output div_status_t           status
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVISOR_W])
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/capture_period_moving_average.sv =====
// Top level of the capture period moving average block.
// Depends on cpma_pkg, cpma_ram, cpma_div and the assertion macro header.
//
// Usage: each input item carries one timestamp from a down-counting timer.
// The first item after reset only records the timestamp and yields no result.
// Every later item yields one result item: the period since the previous
// timestamp (modulo 2^32), the mean of the stored periods, and a flag that is
// set once the window holds WINDOW_DEPTH periods.
// Both channels use valid/ready. in_ready is high only while the sequencer is
// idle. The window is read at the accepting edge, the sum is updated in the
// next cycle and starts the bit-serial divider, the sequencer waits for its
// done, and it then loads the output register, so out_valid is set and in_ready
// returns together. A new item is thus not accepted until the result of the
// last one has been loaded into the output register.
// A stalled receiver holds the result in the output register; a further item
// may be accepted meanwhile, and its result waits until the register is free.
// Reset clears the previous timestamp, fill count, pointer and sum; the window
// memory is not cleared, as every entry is written before it is read.
`include "capture_period_moving_average_macros.svh"

module capture_period_moving_average
    import cpma_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] capture_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] period_ticks,
    output logic [DATA_W-1:0] mean_period_ticks,
    output logic              window_full
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = DATA_W + $clog2(WINDOW_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DATA_W-1:0] period_reg, period_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_period_reg, out_period_next;
    logic [DATA_W-1:0] out_mean_reg, out_mean_next;
    logic              out_full_reg, out_full_next;

    logic              in_accept;
    logic              full_now;
    logic              ram_we;
    logic [DATA_W-1:0] old_period;
    logic              div_start;
    logic [SUM_W-1:0]  div_quotient;
    div_status_t       div_status;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign full_now  = (fill_reg == CNT_W'(WINDOW_DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        sum_next        = sum_reg;
        period_next     = period_reg;
        out_valid_next  = out_valid_reg;
        out_period_next = out_period_reg;
        out_mean_next   = out_mean_reg;
        out_full_next   = out_full_reg;
        ram_we          = 1'b0;
        div_start       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    prev_next      = capture_value;
                    have_prev_next = 1'b1;
                    period_next    = prev_reg - capture_value;
                    if (have_prev_reg)
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                if (full_now)
                begin
                    sum_next = sum_reg + SUM_W'(period_reg) - SUM_W'(old_period);
                end
                else
                begin
                    sum_next  = sum_reg + SUM_W'(period_reg);
                    fill_next = fill_reg + 1'b1;
                end
                ram_we    = 1'b1;
                ptr_next  = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_period_next = period_reg;
                    out_mean_next   = div_quotient[DATA_W-1:0];
                    out_full_next   = full_now;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg     <= period_next;
        out_period_reg <= out_period_next;
        out_mean_reg   <= out_mean_next;
        out_full_reg   <= out_full_next;
    end

    cpma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (period_reg),
        .re    (in_accept),
        .raddr (ptr_reg),
        .rdata (old_period)
    );

    cpma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign out_valid         = out_valid_reg;
    assign period_ticks      = out_period_reg;
    assign mean_period_ticks = out_mean_reg;
    assign window_full       = out_full_reg;

    `CPMA_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(WINDOW_DEPTH))
    `CPMA_ASSERT_IMPLY(a_done_in_div, div_status.done, state_reg == ST_DIV)
    `CPMA_ASSERT_IMPLY(a_full_flag, out_valid_reg && out_full_reg, full_now)
    `CPMA_ASSERT_IMPLY(a_start_idle, div_start, !div_status.busy && have_prev_reg)

endmodule

// ===== bench/capture_period_moving_average_tb.sv =====
// Self-checking testbench for the capture period moving average block.
// Depends on cpma_pkg and the capture_period_moving_average top level; a tracker class
// predicts each period and running mean and compares them with the result items.
module capture_period_moving_average_tb;
    import cpma_pkg::*;

    localparam int WINDOW      = WINDOW_DEPTH_DEFAULT;
    localparam int SUM_W       = DATA_W + $clog2(WINDOW);
    localparam int RANDOM_ITEMS = 1600;
    localparam int SEGMENT     = 48;
    localparam int TAIL_ITEMS  = 200;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;
    localparam int DIRECTED_COUNT = 12;

    localparam logic [DATA_W-1:0] DIRECTED_STAMPS [DIRECTED_COUNT] = '{
        32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
        32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555
    };

    typedef enum int {
        GAP_SHORT,
        GAP_LONGEST,
        GAP_ANY,
        GAP_ZERO,
        GAP_ENCODER
    } gap_mode_e;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] mean;
        logic              full;
    } period_mean_t;

    class period_mean_tracker;
        logic [DATA_W-1:0] last_capture;
        bit                seen_capture;
        int unsigned       filled;
        logic [DATA_W-1:0] window_periods [WINDOW];
        int unsigned       next_slot;
        logic [SUM_W-1:0]  period_sum;
        period_mean_t      expected_means [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            seen_capture = 1'b0;
            last_capture = '0;
            filled       = 0;
            next_slot    = 0;
            period_sum   = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction

        function void note_capture(logic [DATA_W-1:0] stamp);
            logic [DATA_W-1:0] period;
            logic [63:0]       quotient;
            period_mean_t      entry;
            if (!seen_capture)
            begin
                last_capture = stamp;
                seen_capture = 1'b1;
                return;
            end
            period       = last_capture - stamp;
            last_capture = stamp;
            if (filled < WINDOW)
            begin
                filled++;
                period_sum = period_sum + SUM_W'(period);
            end
            else
            begin
                period_sum = period_sum - SUM_W'(window_periods[next_slot]) + SUM_W'(period);
            end
            window_periods[next_slot] = period;
            next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
            entry.full = (filled >= WINDOW);
            quotient = 64'(period_sum) / 64'(entry.full ? WINDOW : filled);
            entry.period = period;
            entry.mean   = quotient[DATA_W-1:0];
            expected_means.push_back(entry);
        endfunction

        function void check_result(logic [DATA_W-1:0] period, logic [DATA_W-1:0] mean,
                                   logic full);
            period_mean_t entry;
            results_seen++;
            if (expected_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Result item %0d arrived with none expected: period %h mean %h full %b",
                             results_seen, period, mean, full);
                return;
            end
            entry = expected_means.pop_front();
            if (period !== entry.period || mean !== entry.mean || full !== entry.full)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Result item %0d: expected period %h mean %h full %b, got %h %h %b",
                             results_seen, entry.period, entry.mean, entry.full,
                             period, mean, full);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] capture_value = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [DATA_W-1:0] period_ticks;
    logic [DATA_W-1:0] mean_period_ticks;
    logic              window_full;

    period_mean_tracker tracker = new();
    bit                 long_hold_request = 1'b0;
    int unsigned        sink_stall_odds = 0;

    capture_period_moving_average #(
        .WINDOW_DEPTH(WINDOW)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .capture_value    (capture_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .period_ticks     (period_ticks),
        .mean_period_ticks(mean_period_ticks),
        .window_full      (window_full)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic offer_capture(input logic [DATA_W-1:0] stamp);
        in_valid      <= 1'b1;
        capture_value <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_capture(stamp);
    endtask

    task automatic pause_source(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_result(period_ticks, mean_period_ticks, window_full);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && sink_stall_odds != 0
                     && $urandom_range(1, sink_stall_odds) == 1)
            begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : capture_source
        logic [DATA_W-1:0] stamp;
        gap_mode_e         mode;
        bit                source_idles;
        mode = GAP_SHORT;
        source_idles = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sink_stall_odds = 4;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            offer_capture(DIRECTED_STAMPS[i]);
            if (i % 3 == 1)
                pause_source($urandom_range(1, 9));
        end
        stamp = $urandom;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % SEGMENT == 0)
            begin
                mode = gap_mode_e'($urandom_range(0, 4));
                source_idles = ($urandom_range(0, 1) == 1);
                case ($urandom_range(0, 2))
                    0: sink_stall_odds = 0;
                    1: sink_stall_odds = 3;
                    default: sink_stall_odds = 8;
                endcase
            end
            if (k >= 600 && k < 600 + WINDOW + 8)
                mode = GAP_LONGEST;
            if (k == HOLD_AT)
                long_hold_request = 1'b1;
            if (k >= RANDOM_ITEMS - TAIL_ITEMS)
            begin
                source_idles = 1'b0;
                sink_stall_odds = 0;
            end
            case (mode)
                GAP_SHORT:   stamp = stamp - DATA_W'($urandom_range(1, 5000));
                GAP_LONGEST: stamp = stamp - (32'hFFFF_FFFF - DATA_W'($urandom_range(0, 7)));
                GAP_ANY:     stamp = $urandom;
                GAP_ZERO:    stamp = stamp - DATA_W'($urandom_range(0, 2));
                default:     stamp = stamp - DATA_W'($urandom_range(1000, 2000000));
            endcase
            offer_capture(stamp);
            if (source_idles && $urandom_range(0, 3) == 0)
                pause_source($urandom_range(1, 9));
        end
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
